// File: sv/mqm_pkg.sv
// shared types and constants for the keyed multi-queue mailbox
// no dependencies
`default_nettype none
package mqm_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned QIDX_W   = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned MAXSZ_W  = 6;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RQ_W     = 4;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned CMD_W    = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET  = 2'd0,
    CMD_SEND = 2'd1,
    CMD_RECV = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_FULL       = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic rlen;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rx_go;
    logic n_zero;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: sv/mqm_ctrl.sv
// controller state machine of the mailbox
// depends on mqm_pkg
`default_nettype none
module mqm_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  mqm_pkg::dp_stat_t    stat_i,
  output mqm_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RLEN   = 5'b00100,
    S_RFETCH = 5'b01000,
    S_RBYTE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.rx_go ? S_RLEN : S_IDLE;
        end
      end
      S_RLEN: begin
        if (stat_i.out_free) begin
          cmd_o.rlen = 1'b1;
          state_d    = stat_i.n_zero ? S_IDLE : S_RFETCH;
        end
      end
      S_RFETCH: state_d = S_RBYTE;
      S_RBYTE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.last ? S_IDLE : S_RFETCH;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/mqm_dp.sv
// datapath of the mailbox: queue table, message memories, output register
// depends on mqm_pkg
`default_nettype none
module mqm_dp #(
  parameter int unsigned NUM_QUEUES      = 16,
  parameter int unsigned SLOTS_PER_QUEUE = 16,
  parameter int unsigned MSG_BYTES       = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  mqm_pkg::ctrl_cmd_t                  cmd_i,
  output mqm_pkg::dp_stat_t                   stat_o,
  input  wire                                 cfg_valid_i,
  input  wire  [mqm_pkg::LIMIT_W-1:0]         cfg_data_i,
  input  wire  [mqm_pkg::CMD_W-1:0]           command_i,
  input  wire  signed [mqm_pkg::KEY_W-1:0]    key_i,
  input  wire  [mqm_pkg::QIDX_W-1:0]          queue_index_i,
  input  wire  [mqm_pkg::BYTE_W-1:0]          data_byte_i,
  input  wire                                 last_byte_i,
  input  wire  [mqm_pkg::MAXSZ_W-1:0]         max_size_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [mqm_pkg::STATUS_W-1:0]        status_o,
  output logic [mqm_pkg::RQ_W-1:0]            result_queue_o,
  output logic [mqm_pkg::BYTE_W-1:0]          out_byte_o,
  output logic                                carries_byte_o,
  output logic [mqm_pkg::CNT_W-1:0]           byte_count_o,
  output logic                                last_result_o
);

  localparam int unsigned QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned SW    = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
  localparam int unsigned CW    = $clog2(SLOTS_PER_QUEUE + 1);
  localparam int unsigned TW    = CW + 1;
  localparam int unsigned LW    = $clog2(MSG_BYTES + 1);
  localparam int unsigned BW    = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int unsigned NSLOT = NUM_QUEUES * SLOTS_PER_QUEUE;
  localparam int unsigned SLW   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int unsigned NBYTE = NSLOT * MSG_BYTES;
  localparam int unsigned AW    = (NBYTE > 1) ? $clog2(NBYTE) : 1;
  localparam int unsigned XW    = 8;

  // input item and configuration
  logic [mqm_pkg::LIMIT_W-1:0] limit_q;
  logic [mqm_pkg::CMD_W-1:0]   cmd_q;
  logic [mqm_pkg::KEY_W-1:0]   key_q;
  logic [mqm_pkg::QIDX_W-1:0]  qidx_q;
  logic [mqm_pkg::BYTE_W-1:0]  data_q;
  logic                        last_q;
  logic [mqm_pkg::MAXSZ_W-1:0] max_q;

  // queue table
  logic [NUM_QUEUES-1:0] in_use_q;
  logic [mqm_pkg::KEY_W-1:0] qkey_q  [NUM_QUEUES];
  logic [SW-1:0]             head_q  [NUM_QUEUES];
  logic [CW-1:0]             count_q [NUM_QUEUES];

  // send and receive progress
  logic                 snd_active_q;
  logic [QW-1:0]        snd_target_q;
  logic [LW-1:0]        snd_len_q;
  mqm_pkg::status_e     snd_err_q;
  logic [SLW-1:0]       rx_slot_q;
  logic [LW-1:0]        rx_n_q;
  logic [LW-1:0]        rx_idx_q;

  // memories
  logic [LW-1:0]              len_mem   [NSLOT];
  logic [mqm_pkg::BYTE_W-1:0] store_mem [NBYTE];
  logic [LW-1:0]              len_rd_q;
  logic [mqm_pkg::BYTE_W-1:0] st_rd_q;

  // output register
  logic                        out_valid_q;
  mqm_pkg::status_e            status_q;
  logic [mqm_pkg::RQ_W-1:0]    rq_q;
  logic [mqm_pkg::BYTE_W-1:0]  ob_q;
  logic                        cb_q;
  logic [mqm_pkg::CNT_W-1:0]   bc_q;
  logic                        lr_q;

  logic [XW-1:0]   qx;
  logic            q_range;
  logic [QW-1:0]   qi;
  logic            q_valid;
  logic [XW-1:0]   lim_x;
  logic [XW-1:0]   eff_lim;
  logic [QW-1:0]   tgt;
  mqm_pkg::status_e err_c;
  logic [LW-1:0]   len_base;
  logic            wr_byte;
  logic [LW-1:0]   new_len;
  logic [TW-1:0]   tail_sum;
  logic [TW-1:0]   tail_red;
  logic [SW-1:0]   tail_idx;
  logic [SLW-1:0]  tail_slot;
  logic [AW-1:0]   wr_addr;
  mqm_pkg::status_e fin_status;
  logic            commit;
  logic [XW-1:0]   new_len_x;
  logic [SLW-1:0]  rx_slot_c;
  logic [XW-1:0]   len_x;
  logic [XW-1:0]   n_x;
  logic [XW-1:0]   max_x;
  logic [AW-1:0]   rd_addr;
  logic [XW-1:0]   rx_n_x;
  logic            found;
  logic [QW-1:0]   found_idx;
  logic            has_free;
  logic [QW-1:0]   free_idx;
  logic            out_free;
  logic            is_send;
  logic            is_recv;
  logic            is_get;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_get   = (cmd_q == mqm_pkg::CMD_GET);
  assign is_send  = (cmd_q == mqm_pkg::CMD_SEND);
  assign is_recv  = (cmd_q == mqm_pkg::CMD_RECV);

  assign qx      = XW'(qidx_q);
  assign q_range = qx < XW'(NUM_QUEUES);
  assign qi      = qx[QW-1:0];
  assign q_valid = q_range && in_use_q[qi];
  assign lim_x   = XW'(limit_q);
  assign eff_lim = (lim_x > XW'(SLOTS_PER_QUEUE)) ? XW'(SLOTS_PER_QUEUE) : lim_x;

  // send path
  always_comb begin
    tgt = snd_active_q ? snd_target_q : qi;
    if (snd_active_q) begin
      err_c = snd_err_q;
    end else if (!q_valid) begin
      err_c = mqm_pkg::ST_INVALID;
    end else if (XW'(count_q[qi]) >= eff_lim) begin
      err_c = mqm_pkg::ST_FULL;
    end else begin
      err_c = mqm_pkg::ST_OK;
    end
    len_base  = snd_active_q ? snd_len_q : '0;
    wr_byte   = (err_c == mqm_pkg::ST_OK) && (XW'(len_base) < XW'(MSG_BYTES));
    new_len   = wr_byte ? LW'(len_base + LW'(1)) : len_base;
    new_len_x = XW'(new_len);
    tail_sum  = TW'(head_q[tgt]) + TW'(count_q[tgt]);
    tail_red  = (tail_sum >= TW'(SLOTS_PER_QUEUE)) ? TW'(tail_sum - TW'(SLOTS_PER_QUEUE))
                                                   : tail_sum;
    tail_idx  = tail_red[SW-1:0];
    tail_slot = SLW'(SLW'(tgt) * SLW'(SLOTS_PER_QUEUE) + SLW'(tail_idx));
    wr_addr   = AW'(AW'(tail_slot) * AW'(MSG_BYTES) + AW'(len_base));
    if (err_c != mqm_pkg::ST_OK) begin
      fin_status = err_c;
    end else if (XW'(count_q[tgt]) >= eff_lim) begin
      fin_status = mqm_pkg::ST_FULL;
    end else begin
      fin_status = mqm_pkg::ST_OK;
    end
    commit = (fin_status == mqm_pkg::ST_OK);
  end

  // receive path
  always_comb begin
    rx_slot_c = SLW'(SLW'(qi) * SLW'(SLOTS_PER_QUEUE) + SLW'(head_q[qi]));
    len_x     = XW'(len_rd_q);
    if (len_x > XW'(MSG_BYTES)) len_x = XW'(MSG_BYTES);
    max_x     = XW'(max_q);
    n_x       = (max_x < len_x) ? max_x : len_x;
    rd_addr   = AW'(AW'(rx_slot_q) * AW'(MSG_BYTES) + AW'(rx_idx_q[BW-1:0]));
    rx_n_x    = XW'(rx_n_q);
  end

  // key search, lowest entry first
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    has_free  = 1'b0;
    free_idx  = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (in_use_q[i] && qkey_q[i] == key_q) begin
        found     = 1'b1;
        found_idx = QW'(i);
      end
      if (!in_use_q[i]) begin
        has_free = 1'b1;
        free_idx = QW'(i);
      end
    end
  end

  assign stat_o.rx_go    = is_recv && q_valid && (count_q[qi] != '0);
  assign stat_o.n_zero   = (n_x == '0);
  assign stat_o.last     = (XW'(rx_idx_q) + XW'(1)) == rx_n_x;
  assign stat_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mqm_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= command_i;
      key_q  <= key_i;
      qidx_q <= queue_index_i;
      data_q <= data_byte_i;
      last_q <= last_byte_i;
      max_q  <= max_size_i;
    end
  end

  // queue table and send state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q     <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      snd_active_q <= 1'b0;
      snd_target_q <= '0;
      snd_len_q    <= '0;
      snd_err_q    <= mqm_pkg::ST_OK;
    end else begin
      if (cmd_i.exec && is_get && !found && has_free) begin
        in_use_q[free_idx] <= 1'b1;
        head_q[free_idx]   <= '0;
        count_q[free_idx]  <= '0;
      end
      if (cmd_i.exec && is_send) begin
        if (last_q) begin
          if (commit) count_q[tgt] <= CW'(count_q[tgt] + CW'(1));
          snd_active_q <= 1'b0;
          snd_len_q    <= '0;
          snd_err_q    <= mqm_pkg::ST_OK;
        end else begin
          snd_active_q <= 1'b1;
          snd_target_q <= tgt;
          snd_len_q    <= new_len;
          snd_err_q    <= err_c;
        end
      end
      if (cmd_i.rlen) begin
        head_q[qi]  <= (XW'(head_q[qi]) + XW'(1) >= XW'(SLOTS_PER_QUEUE)) ? '0
                                                                      : SW'(head_q[qi] + SW'(1));
        count_q[qi] <= CW'(count_q[qi] - CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && is_get && !found && has_free) begin
      qkey_q[free_idx] <= key_q;
    end
    if (cmd_i.exec) rx_slot_q <= rx_slot_c;
    if (cmd_i.rlen) begin
      rx_n_q   <= LW'(n_x);
      rx_idx_q <= '0;
    end
    if (cmd_i.emit) rx_idx_q <= LW'(rx_idx_q + LW'(1));
  end

  // message memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && is_send && wr_byte) store_mem[wr_addr] <= data_q;
    if (cmd_i.exec && is_send && last_q && commit) len_mem[tail_slot] <= new_len;
    len_rd_q <= len_mem[rx_slot_c];
    st_rd_q  <= store_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= (cmd_i.exec && (is_get || (is_recv && !stat_o.rx_go)
                                     || (is_send && last_q)))
                  || (cmd_i.rlen && stat_o.n_zero) || cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && (cmd_i.exec || cmd_i.rlen || cmd_i.emit)) begin
      status_q <= mqm_pkg::ST_OK;
      rq_q     <= '0;
      ob_q     <= '0;
      cb_q     <= 1'b0;
      bc_q     <= '0;
      lr_q     <= 1'b1;
      if (cmd_i.exec) begin
        if (is_get) begin
          if (found) begin
            rq_q <= mqm_pkg::RQ_W'(found_idx);
          end else if (has_free) begin
            rq_q <= mqm_pkg::RQ_W'(free_idx);
          end else begin
            status_q <= mqm_pkg::ST_TABLE_FULL;
          end
        end else if (is_send) begin
          status_q <= fin_status;
          if (commit) bc_q <= new_len_x[mqm_pkg::CNT_W-1:0];
        end else if (!q_valid) begin
          status_q <= mqm_pkg::ST_INVALID;
        end else begin
          status_q <= mqm_pkg::ST_EMPTY;
        end
      end
      if (cmd_i.emit) begin
        ob_q <= st_rd_q;
        cb_q <= 1'b1;
        bc_q <= rx_n_x[mqm_pkg::CNT_W-1:0];
        lr_q <= stat_o.last;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_queue_o = rq_q;
  assign out_byte_o     = ob_q;
  assign carries_byte_o = cb_q;
  assign byte_count_o   = bc_q;
  assign last_result_o  = lr_q;

endmodule
`default_nettype wire

// File: sv/keyed_multi_queue_mailbox_core.sv
// top level of the keyed multi-queue mailbox: controller plus datapath
// get and send are loaded in S_IDLE and executed in S_EXEC, where a send byte commits
// receive: S_EXEC, then S_RLEN, then S_RFETCH and S_RBYTE for each byte (store read port)
// results leave through an output register, the next item is taken while it waits
// reset (async, active low) clears the queue table, send state and sets the limit to 10
// depends on mqm_pkg, mqm_ctrl, mqm_dp
`default_nettype none
module keyed_multi_queue_mailbox_core #(
  parameter int unsigned NUM_QUEUES      = 16,
  parameter int unsigned SLOTS_PER_QUEUE = 16,
  parameter int unsigned MSG_BYTES       = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [mqm_pkg::LIMIT_W-1:0]         cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire  [mqm_pkg::CMD_W-1:0]           command_i,
  input  wire  signed [mqm_pkg::KEY_W-1:0]    key_i,
  input  wire  [mqm_pkg::QIDX_W-1:0]          queue_index_i,
  input  wire  [mqm_pkg::BYTE_W-1:0]          data_byte_i,
  input  wire                                 last_byte_i,
  input  wire  [mqm_pkg::MAXSZ_W-1:0]         max_size_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic [mqm_pkg::STATUS_W-1:0]        status_o,
  output logic [mqm_pkg::RQ_W-1:0]            result_queue_o,
  output logic [mqm_pkg::BYTE_W-1:0]          out_byte_o,
  output logic                                carries_byte_o,
  output logic [mqm_pkg::CNT_W-1:0]           byte_count_o,
  output logic                                last_result_o
);

  mqm_pkg::ctrl_cmd_t cmd;
  mqm_pkg::dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  mqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mqm_dp #(
    .NUM_QUEUES      (NUM_QUEUES),
    .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE),
    .MSG_BYTES       (MSG_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (command_i),
    .key_i          (key_i),
    .queue_index_i  (queue_index_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .max_size_i     (max_size_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_queue_o (result_queue_o),
    .out_byte_o     (out_byte_o),
    .carries_byte_o (carries_byte_o),
    .byte_count_o   (byte_count_o),
    .last_result_o  (last_result_o)
  );

endmodule
`default_nettype wire

// File: sv/mqm_checker.sv
// port-level checks for the mailbox, bound to the top level
// depends on mqm_pkg and keyed_multi_queue_mailbox_core
`default_nettype none
module mqm_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input wire [mqm_pkg::STATUS_W-1:0]   status_o,
  input wire [mqm_pkg::RQ_W-1:0]       result_queue_o,
  input wire [mqm_pkg::BYTE_W-1:0]     out_byte_o,
  input wire                           carries_byte_o,
  input wire [mqm_pkg::CNT_W-1:0]      byte_count_o,
  input wire                           last_result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("result dropped while stalled");

  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !carries_byte_o |-> out_byte_o == '0)
    else $error("out_byte set without a byte");

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && carries_byte_o |->
      status_o == mqm_pkg::ST_OK && result_queue_o == '0 && byte_count_o != '0)
    else $error("bad receive byte result");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != mqm_pkg::ST_OK |-> last_result_o && byte_count_o == '0)
    else $error("error result not single");

  a_only_bytes_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> carries_byte_o)
    else $error("non-final result without a byte");

endmodule

bind keyed_multi_queue_mailbox_core mqm_checker u_mqm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .result_queue_o (result_queue_o),
  .out_byte_o     (out_byte_o),
  .carries_byte_o (carries_byte_o),
  .byte_count_o   (byte_count_o),
  .last_result_o  (last_result_o)
);
`default_nettype wire
